// File: design/cdll_pkg.sv
// ============================================================================
// cdll_pkg: shared types for the circular doubly linked list engine
// Request and status codes, controller states, and the command and status
// groups that join the controller and the datapath.
// ============================================================================
`default_nettype none

package cdll_pkg;

    // request codes
    typedef enum logic [2:0] {
        F_PUSH_FRONT = 3'd0,
        F_PUSH_BACK  = 3'd1,
        F_POP_FRONT  = 3'd2,
        F_POP_BACK   = 3'd3,
        F_READ_AT    = 3'd4,
        F_ERASE_AT   = 3'd5,
        F_SIZE       = 3'd6,
        F_CLEAR      = 3'd7
    } t_func;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_ALLOC,
        S_INS_A,
        S_INS_B,
        S_TAIL,
        S_WALK,
        S_STEP,
        S_GET,
        S_RM_RD,
        S_RM_WR,
        S_FIN
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic    load_req;   // capture request, start slot at head
        logic    rd_head;    // link/value read at head instead of current slot
        logic    set_stat;   // record an error status
        t_status stat;
        logic    alloc;      // pick a free slot
        logic    ins_a;      // write the new node
        logic    ins_b;      // splice neighbors onto the new node
        logic    take_tail;  // current slot <= prev of head
        logic    step;       // current slot <= next, walk count down
        logic    get_val;    // result <= value of current slot
        logic    rem;        // unlink and free current slot
        logic    clear;      // drop every node
        logic    load_out;   // move result into the output register
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        t_func func;
        logic  cnt_zero;
        logic  cnt_full;
        logic  pos_oor;
        logic  walk_zero;
        logic  out_busy;
    } t_dp_status;

endpackage

`default_nettype wire

// File: design/cdll_ifs.sv
// ============================================================================
// cdll request and response channels
// Valid/ready channels carrying one request beat and one response beat.
// ============================================================================
`default_nettype none

interface cdll_req_if;
    logic               valid;
    logic               ready;
    logic        [2:0]  func;
    logic signed [31:0] item_value;
    logic        [3:0]  position;

    modport source (output valid, output func, output item_value, output position,
                    input ready);
    modport sink   (input valid, input func, input item_value, input position,
                    output ready);
endinterface

interface cdll_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_value;
    logic        [4:0]  element_count;
    logic        [1:0]  status;

    modport source (output valid, output result_value, output element_count,
                    output status, input ready);
    modport sink   (input valid, input result_value, input element_count,
                    input status, output ready);
endinterface

`default_nettype wire

// File: design/cdll_ctrl.sv
// ============================================================================
// cdll_ctrl: request sequencer
// Steps each request through decode, slot allocation, link walk, unlink
// and result hand-off by issuing commands to the datapath.
// ============================================================================
`default_nettype none

module cdll_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_req_valid,
    output logic                 o_req_ready,
    input  cdll_pkg::t_dp_status i_stat,
    output cdll_pkg::t_dp_cmd    o_cmd
);

    cdll_pkg::t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cdll_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cdll_pkg::S_IDLE: begin
                if (i_req_valid) n_state = cdll_pkg::S_DECODE;
            end
            cdll_pkg::S_DECODE: begin
                unique case (i_stat.func)
                    cdll_pkg::F_PUSH_FRONT, cdll_pkg::F_PUSH_BACK: begin
                        n_state = i_stat.cnt_full ? cdll_pkg::S_FIN : cdll_pkg::S_ALLOC;
                    end
                    cdll_pkg::F_POP_FRONT: begin
                        n_state = i_stat.cnt_zero ? cdll_pkg::S_FIN : cdll_pkg::S_RM_WR;
                    end
                    cdll_pkg::F_POP_BACK: begin
                        n_state = i_stat.cnt_zero ? cdll_pkg::S_FIN : cdll_pkg::S_TAIL;
                    end
                    cdll_pkg::F_READ_AT, cdll_pkg::F_ERASE_AT: begin
                        if (i_stat.cnt_zero || i_stat.pos_oor) n_state = cdll_pkg::S_FIN;
                        else n_state = cdll_pkg::S_WALK;
                    end
                    default: begin
                        n_state = cdll_pkg::S_FIN;
                    end
                endcase
            end
            cdll_pkg::S_ALLOC: n_state = cdll_pkg::S_INS_A;
            cdll_pkg::S_INS_A: begin
                n_state = i_stat.cnt_zero ? cdll_pkg::S_FIN : cdll_pkg::S_INS_B;
            end
            cdll_pkg::S_INS_B: n_state = cdll_pkg::S_FIN;
            cdll_pkg::S_TAIL:  n_state = cdll_pkg::S_RM_RD;
            cdll_pkg::S_WALK: begin
                if (!i_stat.walk_zero) n_state = cdll_pkg::S_STEP;
                else if (i_stat.func == cdll_pkg::F_READ_AT) n_state = cdll_pkg::S_GET;
                else n_state = cdll_pkg::S_RM_WR;
            end
            cdll_pkg::S_STEP:  n_state = cdll_pkg::S_WALK;
            cdll_pkg::S_GET:   n_state = cdll_pkg::S_FIN;
            cdll_pkg::S_RM_RD: n_state = cdll_pkg::S_RM_WR;
            cdll_pkg::S_RM_WR: n_state = cdll_pkg::S_FIN;
            cdll_pkg::S_FIN: begin
                if (!i_stat.out_busy) n_state = cdll_pkg::S_IDLE;
            end
            default: n_state = cdll_pkg::S_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd       = '0;
        o_cmd.stat  = cdll_pkg::ST_OK;
        o_req_ready = 1'b0;
        unique case (r_state)
            cdll_pkg::S_IDLE: begin
                o_req_ready    = 1'b1;
                o_cmd.load_req = i_req_valid;
            end
            cdll_pkg::S_DECODE: begin
                o_cmd.rd_head = 1'b1;
                unique case (i_stat.func)
                    cdll_pkg::F_PUSH_FRONT, cdll_pkg::F_PUSH_BACK: begin
                        o_cmd.set_stat = i_stat.cnt_full;
                        o_cmd.stat     = cdll_pkg::ST_FULL;
                    end
                    cdll_pkg::F_POP_FRONT, cdll_pkg::F_POP_BACK: begin
                        o_cmd.set_stat = i_stat.cnt_zero;
                        o_cmd.stat     = cdll_pkg::ST_EMPTY;
                    end
                    cdll_pkg::F_READ_AT, cdll_pkg::F_ERASE_AT: begin
                        o_cmd.set_stat = i_stat.cnt_zero || i_stat.pos_oor;
                        o_cmd.stat     = i_stat.cnt_zero ? cdll_pkg::ST_EMPTY
                                                         : cdll_pkg::ST_RANGE;
                    end
                    cdll_pkg::F_CLEAR: begin
                        o_cmd.clear = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            cdll_pkg::S_ALLOC: begin
                o_cmd.rd_head = 1'b1;
                o_cmd.alloc   = 1'b1;
            end
            cdll_pkg::S_INS_A: o_cmd.ins_a     = 1'b1;
            cdll_pkg::S_INS_B: o_cmd.ins_b     = 1'b1;
            cdll_pkg::S_TAIL:  o_cmd.take_tail = 1'b1;
            cdll_pkg::S_WALK: begin
            end
            cdll_pkg::S_STEP:  o_cmd.step      = 1'b1;
            cdll_pkg::S_GET:   o_cmd.get_val   = 1'b1;
            cdll_pkg::S_RM_RD: begin
            end
            cdll_pkg::S_RM_WR: o_cmd.rem       = 1'b1;
            cdll_pkg::S_FIN:   o_cmd.load_out  = !i_stat.out_busy;
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// File: design/cdll_dp.sv
// ============================================================================
// cdll_dp: list datapath
// Node value and link memories, a free-slot stack with a fresh-slot
// counter, head and count registers, and the output register.
// ============================================================================
`default_nettype none

module cdll_dp #(
    parameter int CAPACITY = 16
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  cdll_pkg::t_dp_cmd    i_cmd,
    output cdll_pkg::t_dp_status o_stat,
    input  wire  [2:0]           i_func,
    input  wire  signed [31:0]   i_item_value,
    input  wire  [3:0]           i_position,
    input  wire                  i_out_ready,
    output logic                 o_out_valid,
    output logic signed [31:0]   o_result_value,
    output logic [4:0]           o_element_count,
    output logic [1:0]           o_status
);

    localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > 5) ? CNT_W : 5;

    // node storage
    logic signed [31:0]  m_val  [CAPACITY];
    logic [SLOT_W-1:0]   m_next [CAPACITY];
    logic [SLOT_W-1:0]   m_prev [CAPACITY];
    logic [SLOT_W-1:0]   m_free [CAPACITY];

    // request and list state
    cdll_pkg::t_func     r_func;
    logic signed [31:0]  r_value;
    logic [3:0]          r_pos;
    logic [3:0]          r_walk;
    logic [SLOT_W-1:0]   r_head, r_slot, r_tail;
    logic [CNT_W-1:0]    r_count, r_fresh, r_fsp;
    logic signed [31:0]  r_res;
    cdll_pkg::t_status   r_stat;

    // registered read data
    logic signed [31:0]  r_val_rd;
    logic [SLOT_W-1:0]   r_next_rd, r_prev_rd, r_free_rd;

    logic [SLOT_W-1:0]   rd_addr, fsp_m1, new_slot;
    logic                single;
    logic [CMP_W-1:0]    cnt_ext, pos_ext;
    logic [CNT_W-1:0]    fsp_dec;

    assign rd_addr  = i_cmd.rd_head ? r_head : r_slot;
    assign fsp_dec  = r_fsp - CNT_W'(1);
    assign fsp_m1   = fsp_dec[SLOT_W-1:0];
    assign single   = (r_count == '0);
    assign new_slot = (r_fsp != '0) ? r_free_rd : r_fresh[SLOT_W-1:0];
    assign cnt_ext  = CMP_W'(r_count);
    assign pos_ext  = CMP_W'(r_pos);

    // status to the controller
    always_comb begin
        o_stat.func      = r_func;
        o_stat.cnt_zero  = single;
        o_stat.cnt_full  = (r_count == CNT_W'(CAPACITY));
        o_stat.pos_oor   = (pos_ext >= cnt_ext);
        o_stat.walk_zero = (r_walk == '0);
        o_stat.out_busy  = o_out_valid && !i_out_ready;
    end

    // memory reads, registered: node memories at rd_addr, free stack at its top
    always_ff @(posedge i_clk) begin
        r_val_rd  <= m_val[rd_addr];
        r_next_rd <= m_next[rd_addr];
        r_prev_rd <= m_prev[rd_addr];
        r_free_rd <= m_free[fsp_m1];
    end

    // value memory write
    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_a) m_val[r_slot] <= r_value;
    end

    // next link write
    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_a) m_next[r_slot] <= single ? r_slot : r_head;
        else if (i_cmd.ins_b) m_next[r_tail] <= r_slot;
        else if (i_cmd.rem) m_next[r_prev_rd] <= r_next_rd;
    end

    // prev link write
    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_a) m_prev[r_slot] <= single ? r_slot : r_prev_rd;
        else if (i_cmd.ins_b) m_prev[r_head] <= r_slot;
        else if (i_cmd.rem) m_prev[r_next_rd] <= r_prev_rd;
    end

    // free stack push
    always_ff @(posedge i_clk) begin
        if (i_cmd.rem) m_free[r_fsp[SLOT_W-1:0]] <= r_slot;
    end

    // request capture and working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_func  <= cdll_pkg::t_func'(i_func);
            r_value <= i_item_value;
            r_pos   <= i_position;
            r_walk  <= i_position;
            r_slot  <= r_head;
            r_res   <= '0;
            r_stat  <= cdll_pkg::ST_OK;
        end
        if (i_cmd.set_stat) r_stat <= i_cmd.stat;
        if (i_cmd.alloc) r_slot <= new_slot;
        if (i_cmd.ins_a) r_tail <= r_prev_rd;
        if (i_cmd.take_tail) r_slot <= r_prev_rd;
        if (i_cmd.step) begin
            r_slot <= r_next_rd;
            r_walk <= r_walk - 4'd1;
        end
        if (i_cmd.get_val || i_cmd.rem) r_res <= r_val_rd;
    end

    // head, count and slot allocator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_fresh <= '0;
            r_fsp   <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_head  <= '0;
                r_count <= '0;
                r_fresh <= '0;
                r_fsp   <= '0;
            end
            if (i_cmd.alloc) begin
                if (r_fsp != '0) r_fsp <= fsp_dec;
                else r_fresh <= r_fresh + CNT_W'(1);
            end
            if (i_cmd.ins_a && single) begin
                r_head  <= r_slot;
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.ins_b) begin
                if (r_func == cdll_pkg::F_PUSH_FRONT) r_head <= r_slot;
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.rem) begin
                r_fsp   <= r_fsp + CNT_W'(1);
                r_count <= r_count - CNT_W'(1);
                if (r_count == CNT_W'(1)) r_head <= '0;
                else if (r_slot == r_head) r_head <= r_next_rd;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_result_value  <= r_res;
            o_element_count <= cnt_ext[4:0];
            o_status        <= r_stat;
        end
    end

endmodule

`default_nettype wire

// File: design/circular_doubly_linked_list_engine.sv
// ============================================================================
// circular_doubly_linked_list_engine: bounded circular linked list
// Push, pop, indexed read and erase, size and clear on a list of up to
// CAPACITY signed 32-bit values held in slot memories.
// ============================================================================
//
//  channel  dir  beat contents                           handshake
//  i_req    in   func, item_value, position              valid/ready
//  o_rsp    out  result_value, element_count, status     valid/ready
//
//  One request at a time. Size, clear and errors go from decode to the
//  result; push allocates and writes a node, then splices neighbors if
//  the list was not empty; pop front unlinks the head, pop back the tail;
//  read/erase at p walk p next links through the registered link read.
//  Reset clears head, count and the slot allocator at once; no sweep.
//  A held output beat does not block acceptance of the next request.
`default_nettype none

module circular_doubly_linked_list_engine #(
    parameter int CAPACITY = 16
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    cdll_req_if.sink   i_req,
    cdll_rsp_if.source o_rsp
);

    cdll_pkg::t_dp_cmd    cmd;
    cdll_pkg::t_dp_status stat;
    logic                 req_ready;

    assign i_req.ready = req_ready;

    // sequencer
    cdll_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (req_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // storage and output
    cdll_dp #(.CAPACITY(CAPACITY)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_func          (i_req.func),
        .i_item_value    (i_req.item_value),
        .i_position      (i_req.position),
        .i_out_ready     (o_rsp.ready),
        .o_out_valid     (o_rsp.valid),
        .o_result_value  (o_rsp.result_value),
        .o_element_count (o_rsp.element_count),
        .o_status        (o_rsp.status)
    );

endmodule

`default_nettype wire

// File: design/cdll_checker.sv
// ============================================================================
// cdll_checker: port-level checks for the linked list engine
// Watches the response channel for hold, reset and status consistency.
// ============================================================================
`default_nettype none

module cdll_checker #(
    parameter int CAPACITY = 16
) (
    input wire               i_clk,
    input wire               i_rst_n,
    input wire               i_out_valid,
    input wire               i_out_ready,
    input wire signed [31:0] i_result_value,
    input wire [4:0]         i_element_count,
    input wire [1:0]         i_status
);

    // stalled response beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_result_value)
            && $stable(i_element_count) && $stable(i_status))
        else $error("response beat changed while stalled");

    // no response right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("response valid after reset");

    // an error carries a zero result
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status != cdll_pkg::ST_OK) |-> i_result_value == 32'sd0)
        else $error("error response with nonzero result");

    // empty status only on an empty list
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == cdll_pkg::ST_EMPTY) |-> i_element_count == 5'd0)
        else $error("empty status with nonzero count");

    // count stays within capacity
    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (CAPACITY >= 31) || (32'(i_element_count) <= 32'(CAPACITY)))
        else $error("element count above capacity");

endmodule

bind circular_doubly_linked_list_engine cdll_checker #(.CAPACITY(CAPACITY)) u_cdll_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_rsp.valid),
    .i_out_ready     (o_rsp.ready),
    .i_result_value  (o_rsp.result_value),
    .i_element_count (o_rsp.element_count),
    .i_status        (o_rsp.status)
);

`default_nettype wire
